// ----- rtl/lru_set_assoc_cache_tags_macros.svh -----
// Assertion macros shared by the checker of lru_set_assoc_cache_tags.
// No dependencies; take it in by `include before the module that asserts.
`ifndef LRU_SET_ASSOC_CACHE_TAGS_MACROS_SVH
`define LRU_SET_ASSOC_CACHE_TAGS_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define LSACT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define LSACT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define LSACT_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lsact_pkg.sv -----
// Package for the LRU set-associative tag cache: widths, codes, state type.
// No dependencies; used by the top level and its checker.
package lsact_pkg;

    // Parameter defaults
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;

    // Field widths
    localparam int ADDR_W    = 64;
    localparam int OP_W      = 2;
    localparam int TAG_W     = 62;
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int HITS_W    = 2;

    // Configuration register widths
    localparam int SB_W      = 4;   // holds the clamped set_bits, up to 7
    localparam int SB_RAW_W  = 3;
    localparam int BB_W      = 6;
    localparam int WAYS_RAW_W = 4;
    localparam int WC_W      = 5;   // holds the clamped way count, up to 15
    localparam int SH_W      = 7;   // block_bits + set_bits
    localparam logic [BB_W-1:0] BLOCK_MAX = 6'd32;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = ADDR_W;
    localparam int S_TUSER_W  = OP_W;
    localparam int M_TDATA_W  = 104;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Result packing, lowest bit up
    localparam int OUT_HITS_LSB   = 0;
    localparam int OUT_MISSED_BIT = 2;
    localparam int OUT_EVICT_BIT  = 3;
    localparam int OUT_THIT_LSB   = 4;
    localparam int OUT_TMISS_LSB  = 36;
    localparam int OUT_TEVICT_LSB = 68;
    localparam int OUT_USED_W     = 100;

    // Operation codes
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OP_W-1:0] OP_IFETCH = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

    // Hit count that a miss never reaches
    localparam logic [HITS_W-1:0] HITS_TWO = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

// ----- rtl/lru_set_assoc_cache_tags.sv -----
// Tag-only set-associative cache with LRU replacement, one set row per memory word.
// Depends on lsact_pkg. An accepted access reads its set row into registers, is looked up
// in ST_LOOKUP and lands in the output register, where a stalled result holds it.
// One access at a time: a new one is taken only once the lookup has written back the row.
// Reset (synchronous, active low): row valid bits clear together, with no clearing
// pass; access clock to one, totals to zero, registers to 4, 4 and 1.
module lru_set_assoc_cache_tags #(
    parameter int MAX_SET_BITS = lsact_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = lsact_pkg::DEF_MAX_WAYS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Access stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lsact_pkg::S_TDATA_W-1:0]   s_tdata,   // [63:0] address
    input  logic [lsact_pkg::S_TUSER_W-1:0]   s_tuser,   // [1:0] operation
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] hits_now, [2] missed, [3] evicted, [35:4] total_hits,
    // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
    output logic [lsact_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lsact_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lsact_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lsact_pkg::*;

    localparam int SETS  = 1 << MAX_SET_BITS;
    localparam int SET_W = MAX_SET_BITS;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LVL   = $clog2(MAX_WAYS);
    localparam int NPOW  = 1 << LVL;

    // Saturating add of a small increment to a running total
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input logic [HITS_W-1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, v} + {{(CNT_W+1-HITS_W){1'b0}}, inc};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers: always ready, raw values held, clamped on use
    // ------------------------------------------------------------------
    logic [SB_RAW_W-1:0]   r_set_bits;
    logic [BB_W-1:0]       r_block_bits;
    logic [WAYS_RAW_W-1:0] r_ways;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= SB_RAW_W'(4);
            r_block_bits <= BB_W'(4);
            r_ways       <= WAYS_RAW_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SET_BITS:   r_set_bits   <= i_cfg_data[SB_RAW_W-1:0];
                REG_BLOCK_BITS: r_block_bits <= i_cfg_data[BB_W-1:0];
                REG_WAYS:       r_ways       <= i_cfg_data[WAYS_RAW_W-1:0];
                default:        ; // writes beyond the register list are dropped
            endcase
        end
    end

    // Effective geometry: set_bits into 1..MAX_SET_BITS, block_bits into 1..32,
    // ways into 1..MAX_WAYS.
    logic [SB_W-1:0] s_eff;
    logic [BB_W-1:0] b_eff;
    logic [WC_W-1:0] e_eff;

    always_comb begin
        if (r_set_bits == '0)
            s_eff = SB_W'(1);
        else if (SB_W'(r_set_bits) > SB_W'(MAX_SET_BITS))
            s_eff = SB_W'(MAX_SET_BITS);
        else
            s_eff = SB_W'(r_set_bits);

        if (r_block_bits == '0)
            b_eff = BB_W'(1);
        else if (r_block_bits > BLOCK_MAX)
            b_eff = BLOCK_MAX;
        else
            b_eff = r_block_bits;

        if (r_ways == '0)
            e_eff = WC_W'(1);
        else if (WC_W'(r_ways) > WC_W'(MAX_WAYS))
            e_eff = WC_W'(MAX_WAYS);
        else
            e_eff = WC_W'(r_ways);
    end

    // ------------------------------------------------------------------
    // Address split on the incoming transaction
    // ------------------------------------------------------------------
    logic [SH_W-1:0]   tag_shamt;
    logic [ADDR_W-1:0] set_shifted;
    logic [SET_W-1:0]  set_mask;
    logic [SET_W-1:0]  in_set;
    logic [TAG_W-1:0]  in_tag;

    always_comb begin
        tag_shamt   = SH_W'(b_eff) + SH_W'(s_eff);
        set_shifted = s_tdata >> b_eff;
        set_mask    = ~({SET_W{1'b1}} << s_eff);
        in_set      = set_shifted[SET_W-1:0] & set_mask;
        in_tag      = TAG_W'(s_tdata >> tag_shamt);
    end

    // ------------------------------------------------------------------
    // Control: idle, then a lookup state that completes into the
    // output register once that register is free
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;
    logic   s_acc;
    logic   lookup_fire;
    logic   r_out_vld;

    assign s_acc = s_tvalid && s_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (s_acc) n_state = ST_LOOKUP;
            ST_LOOKUP: if (!r_out_vld || m_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = (r_state == ST_IDLE);
        lookup_fire = (r_state == ST_LOOKUP) && (!r_out_vld || m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Transaction held through the lookup
    logic [OP_W-1:0]  r_op;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op  <= s_tuser;
            r_set <= in_set;
            r_tag <= in_tag;
        end
    end

    // ------------------------------------------------------------------
    // Set row memories: one word per set, all ways side by side.
    // Tags need no reset; stamps read as zero until the row's valid bit is set.
    // The write-back lands before the next read can be issued, so no forwarding.
    // ------------------------------------------------------------------
    logic [MAX_WAYS*TAG_W-1:0]   r_tag_mem [SETS];
    logic [MAX_WAYS*STAMP_W-1:0] r_stp_mem [SETS];
    logic [SETS-1:0]             r_row_vld;
    logic [MAX_WAYS*TAG_W-1:0]   r_tag_rd;
    logic [MAX_WAYS*STAMP_W-1:0] r_stp_rd;
    logic                        r_row_vld_rd;
    logic [MAX_WAYS*TAG_W-1:0]   n_tag_row;
    logic [MAX_WAYS*STAMP_W-1:0] n_stp_row;
    logic                        wr_tag;
    logic                        wr_stp;

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_tag_rd <= r_tag_mem[in_set];
            r_stp_rd <= r_stp_mem[in_set];
        end
        if (wr_tag) r_tag_mem[r_set] <= n_tag_row;
        if (wr_stp) r_stp_mem[r_set] <= n_stp_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else begin
            if (wr_stp) r_row_vld[r_set] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) r_row_vld_rd <= r_row_vld[in_set];
    end

    // ------------------------------------------------------------------
    // Lookup: compare all ways, pick the LRU victim through a tree
    // ------------------------------------------------------------------
    logic [STAMP_W-1:0] stp_way [MAX_WAYS];
    logic [MAX_WAYS-1:0] way_en;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [WAY_W-1:0]    hit_way;
    logic                hit;

    always_comb begin
        hit_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            stp_way[w] = r_row_vld_rd ? r_stp_rd[w*STAMP_W +: STAMP_W] : '0;
            way_en[w]  = (WC_W'(w) < e_eff);
            hit_vec[w] = way_en[w] && (stp_way[w] != '0)
                         && (r_tag_rd[w*TAG_W +: TAG_W] == r_tag);
        end
        // lowest hitting way wins
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) hit_way = WAY_W'(w);
        end
        hit = |hit_vec;
    end

    // Min tree, heap layout with leaves at NPOW..2*NPOW-1. On a tie the higher
    // way wins; disabled ways never win, and way 0 is always enabled.
    logic [WAY_W-1:0]   tr_idx [1:2*NPOW-1];
    logic [STAMP_W-1:0] tr_stp [1:2*NPOW-1];
    logic               tr_en  [1:2*NPOW-1];

    always_comb begin
        for (int w = 0; w < NPOW; w++) begin
            if (w < MAX_WAYS) begin
                tr_idx[NPOW+w] = WAY_W'(w);
                tr_stp[NPOW+w] = stp_way[w];
                tr_en[NPOW+w]  = way_en[w];
            end else begin
                tr_idx[NPOW+w] = '0;
                tr_stp[NPOW+w] = '0;
                tr_en[NPOW+w]  = 1'b0;
            end
        end
        for (int i = NPOW - 1; i >= 1; i--) begin
            if (tr_en[2*i+1] && (!tr_en[2*i] || (tr_stp[2*i+1] <= tr_stp[2*i]))) begin
                tr_idx[i] = tr_idx[2*i+1];
                tr_stp[i] = tr_stp[2*i+1];
                tr_en[i]  = 1'b1;
            end else begin
                tr_idx[i] = tr_idx[2*i];
                tr_stp[i] = tr_stp[2*i];
                tr_en[i]  = tr_en[2*i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Update: write back the row, advance clock and totals
    // ------------------------------------------------------------------
    logic [STAMP_W-1:0] r_acc_clock;
    logic [CNT_W-1:0]   r_hit_tot;
    logic [CNT_W-1:0]   r_miss_tot;
    logic [CNT_W-1:0]   r_evict_tot;
    logic               active;
    logic               is_modify;
    logic               missed;
    logic               evicted;
    logic [HITS_W-1:0]  hits_now;
    logic [WAY_W-1:0]   upd_way;
    logic [CNT_W-1:0]   n_hit_tot;
    logic [CNT_W-1:0]   n_miss_tot;
    logic [CNT_W-1:0]   n_evict_tot;
    logic [STAMP_W-1:0] n_acc_clock;

    always_comb begin
        active    = (r_op != OP_IFETCH);
        is_modify = (r_op == OP_MODIFY);
        missed    = active && !hit;
        evicted   = missed && (tr_stp[1] != '0);
        hits_now  = active ? (HITS_W'(hit) + HITS_W'(is_modify)) : '0;
        upd_way   = hit ? hit_way : tr_idx[1];

        for (int w = 0; w < MAX_WAYS; w++) begin
            n_tag_row[w*TAG_W +: TAG_W] = (WAY_W'(w) == upd_way) ? r_tag
                                          : r_tag_rd[w*TAG_W +: TAG_W];
            n_stp_row[w*STAMP_W +: STAMP_W] = (WAY_W'(w) == upd_way) ? r_acc_clock
                                              : stp_way[w];
        end
        wr_stp = lookup_fire && active;
        wr_tag = lookup_fire && missed;

        n_hit_tot   = sat_add(r_hit_tot, hits_now);
        n_miss_tot  = sat_add(r_miss_tot, HITS_W'(missed));
        n_evict_tot = sat_add(r_evict_tot, HITS_W'(evicted));
        // skip zero on wrap so a written line never looks invalid
        n_acc_clock = (r_acc_clock == '1) ? STAMP_W'(1) : r_acc_clock + STAMP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_clock <= STAMP_W'(1);
            r_hit_tot   <= '0;
            r_miss_tot  <= '0;
            r_evict_tot <= '0;
        end else if (lookup_fire) begin
            r_hit_tot   <= n_hit_tot;
            r_miss_tot  <= n_miss_tot;
            r_evict_tot <= n_evict_tot;
            if (active) r_acc_clock <= n_acc_clock;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold the result until the transaction completes
    // ------------------------------------------------------------------
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TDATA_W-1:0] n_out_data;

    always_comb begin
        n_out_data = '0;
        n_out_data[OUT_HITS_LSB +: HITS_W]  = hits_now;
        n_out_data[OUT_MISSED_BIT]          = missed;
        n_out_data[OUT_EVICT_BIT]           = evicted;
        n_out_data[OUT_THIT_LSB +: CNT_W]   = n_hit_tot;
        n_out_data[OUT_TMISS_LSB +: CNT_W]  = n_miss_tot;
        n_out_data[OUT_TEVICT_LSB +: CNT_W] = n_evict_tot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (lookup_fire) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lookup_fire) r_out_data <= n_out_data;
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_out_data;

endmodule

// ----- rtl/lsact_checker.sv -----
// Port-level checker for lru_set_assoc_cache_tags, attached by bind below.
// Depends on lsact_pkg and lru_set_assoc_cache_tags_macros.svh.
`include "lru_set_assoc_cache_tags_macros.svh"

module lsact_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lsact_pkg::M_TDATA_W-1:0] m_tdata
);
    import lsact_pkg::*;

    // Output register empties on reset
    `LSACT_ASSERT_NXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !m_tvalid, "result valid after reset")

    // One access at a time: no new transaction straight after one is taken
    `LSACT_ASSERT_NXT(a_one_inflight, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready, "back-to-back accept")

    // An eviction only happens on a miss
    `LSACT_ASSERT_IMP(a_evict_miss, i_clk, i_rst_n, m_tvalid && m_tdata[OUT_EVICT_BIT], m_tdata[OUT_MISSED_BIT], "eviction without miss")

    // A miss counts at most the modify hit
    `LSACT_ASSERT_IMP(a_miss_hits, i_clk, i_rst_n, m_tvalid && m_tdata[OUT_MISSED_BIT], m_tdata[OUT_HITS_LSB +: HITS_W] != HITS_TWO, "miss with two hits")

    // A stalled result holds
    `LSACT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind lru_set_assoc_cache_tags lsact_checker u_lsact_checker (.*);
